// ===== hdl/vad_pkg.sv =====
// Package for the vector angle core: widths, angle constants and the CORDIC
// arctangent table in degrees. No dependencies.
`default_nettype none

package vad_pkg;

  localparam int COORD_BITS    = 16;
  localparam int FRAC_BITS     = 7;
  localparam int CORDIC_STAGES = 18;

  // Angle accumulator scale: degrees with 16 fraction bits.
  localparam int ANG_FRAC = 16;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int MAG_W    = COORD_BITS;
  localparam int MSB_W    = $clog2(MAG_W);
  localparam int NORM_MSB = 58;
  localparam int SH_W     = 6;
  localparam int CX_W     = 62;
  localparam int Z_W      = 25;
  localparam int ANG_W    = 27;
  localparam int IDX_W    = 5;
  localparam int OUT_W    = 17;

  localparam int IN_W         = 4 * COORD_BITS;
  localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  localparam int RND_S    = ANG_FRAC - FRAC_BITS;
  localparam int RND_HALF = (1 << RND_S) >> 1;

  localparam logic signed [Z_W-1:0]   Z_DEG90   = Z_W'(90 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] T_DEG180  = ANG_W'(180 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] T_DEG360  = ANG_W'(360 << ANG_FRAC);
  localparam logic signed [ANG_W-1:0] T_HALF    = ANG_W'(RND_HALF);
  localparam logic signed [ANG_W-1:0] R_DEG90   = ANG_W'(90 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] R_DEG270  = ANG_W'(270 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] R_DEG360  = ANG_W'(360 << FRAC_BITS);
  localparam logic signed [ANG_W-1:0] R_DEGM90  = -R_DEG90;

  typedef enum logic [1:0] {
    MODE_FULL   = 2'd0,
    MODE_SIGNED = 2'd1,
    MODE_LINE   = 2'd2
  } angle_mode_e;

  // Signs and zero flags of the difference vector, carried beside the data.
  typedef struct packed {
    logic dx_zero;
    logic dx_pos;
    logic dy_zero;
    logic dy_neg;
  } side_t;

  // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/vector_angle_degrees_core.sv =====
// Register stages from input accept to output valid: three front-end stages, one
// per CORDIC iteration, two back-end.
// Throughput: one item per cycle; the whole pipeline advances together and holds
// while a result waits on m_axis_tready. Reset clears all valid bits and sets
// angle_mode to full circle; data registers are not reset.
// Top level of the vector angle core. Depends on vad_pkg, vad_prep,
// vad_cordic_stage and vad_finish.
`default_nettype none

module vector_angle_degrees_core
  import vad_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [1:0]             cfg_wdata_i,   // angle_mode
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata   // angle_out, zero pad
);

  logic [1:0] angle_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_mode_q <= MODE_FULL;
    end else if (cfg_we_i) begin
      angle_mode_q <= cfg_wdata_i;
    end
  end

  // Single enable for every stage: a held result freezes the pipeline.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  logic                   vld_s  [CORDIC_STAGES+1];
  logic signed [CX_W-1:0] cx_s   [CORDIC_STAGES+1];
  logic signed [CX_W-1:0] cy_s   [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  z_s    [CORDIC_STAGES+1];
  side_t                  side_s [CORDIC_STAGES+1];

  vad_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .vld_i     (s_axis_tvalid),
    .start_x_i (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i   (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .vld_o     (vld_s[0]),
    .cx_o      (cx_s[0]),
    .cy_o      (cy_s[0]),
    .side_o    (side_s[0])
  );

  assign z_s[0] = '0;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    vad_cordic_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .idx_i  (IDX_W'(g)),
      .vld_i  (vld_s[g]),
      .cx_i   (cx_s[g]),
      .cy_i   (cy_s[g]),
      .z_i    (z_s[g]),
      .side_i (side_s[g]),
      .vld_o  (vld_s[g+1]),
      .cx_o   (cx_s[g+1]),
      .cy_o   (cy_s[g+1]),
      .z_o    (z_s[g+1]),
      .side_o (side_s[g+1])
    );
  end

  logic signed [OUT_W-1:0] angle_out;

  vad_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .mode_i  (angle_mode_q),
    .vld_i   (vld_s[CORDIC_STAGES]),
    .z_i     (z_s[CORDIC_STAGES]),
    .side_i  (side_s[CORDIC_STAGES]),
    .vld_o   (m_axis_tvalid),
    .angle_o (angle_out)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-OUT_W){1'b0}}, angle_out};

  localparam logic signed [ANG_W-1:0] R_DEG180_OUT = ANG_W'(180 << FRAC_BITS);

  // Form ranges; user changes configuration only with pipeline empty (not enforced).
  a_full_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && angle_mode_q != MODE_SIGNED && angle_mode_q != MODE_LINE
    |-> angle_out >= 0 && angle_out < R_DEG360)
    else $error("full-circle angle out of range");

  a_signed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && angle_mode_q == MODE_SIGNED
    |-> angle_out >= -(R_DEG180_OUT) && angle_out <= R_DEG180_OUT)
    else $error("signed angle out of range");

  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && angle_mode_q == MODE_LINE
    |-> angle_out >= R_DEGM90 && angle_out <= R_DEG90)
    else $error("line angle out of range");

endmodule

`default_nettype wire

// ===== hdl/vad_prep.sv =====
// Front end: coordinate differences, magnitudes and normalization of the
// vector for CORDIC. Three register stages. Depends on vad_pkg.
`default_nettype none

module vad_prep
  import vad_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         vld_i,
  input  wire logic signed [COORD_BITS-1:0] start_x_i,
  input  wire logic signed [COORD_BITS-1:0] start_y_i,
  input  wire logic signed [COORD_BITS-1:0] end_x_i,
  input  wire logic signed [COORD_BITS-1:0] end_y_i,
  output logic                              vld_o,
  output logic signed [CX_W-1:0]            cx_o,
  output logic signed [CX_W-1:0]            cy_o,
  output side_t                             side_o
);

  // Stage 1: differences.
  logic                     vld1_q;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  side_t                    side1_d, side1_q;

  always_comb begin
    dx_d = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
    dy_d = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};
    side1_d.dx_zero = (dx_d == '0);
    side1_d.dx_pos  = !dx_d[DIFF_W-1] && (dx_d != '0);
    side1_d.dy_zero = (dy_d == '0);
    side1_d.dy_neg  = dy_d[DIFF_W-1];
  end

  // Stage 2: magnitudes and the shift that brings the larger one to bit 58.
  logic                   vld2_q;
  logic [DIFF_W-1:0]      ax_full, ay_full;
  logic [MAG_W-1:0]       ax_d, ay_d, mx, ax_q, ay_q;
  logic [MSB_W-1:0]       msb;
  logic [SH_W-1:0]        sh_d, sh_q;
  side_t                  side2_q;

  always_comb begin
    ax_full = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    ay_full = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    ax_d    = ax_full[MAG_W-1:0];
    ay_d    = ay_full[MAG_W-1:0];
    mx      = (ax_d > ay_d) ? ax_d : ay_d;
    msb     = '0;
    for (int j = 0; j < MAG_W; j++) begin
      if (mx[j]) msb = MSB_W'(j);
    end
    sh_d = SH_W'(NORM_MSB) - SH_W'(msb);
  end

  // Stage 3: normalized CORDIC start vector.
  logic                  vld3_q;
  logic signed [CX_W-1:0] cx_q, cy_q;
  side_t                 side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      side1_q <= side1_d;
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      sh_q    <= sh_d;
      side2_q <= side1_q;
      cx_q    <= $signed(CX_W'(ax_q) << sh_q);
      cy_q    <= $signed(CX_W'(ay_q) << sh_q);
      side3_q <= side2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign side_o = side3_q;

endmodule

`default_nettype wire

// ===== hdl/vad_cordic_stage.sv =====
// One CORDIC vectoring iteration with its output register; the iteration
// index comes in as a tied constant. Depends on vad_pkg.
`default_nettype none

module vad_cordic_stage
  import vad_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [IDX_W-1:0]       idx_i,
  input  wire logic                   vld_i,
  input  wire logic signed [CX_W-1:0] cx_i,
  input  wire logic signed [CX_W-1:0] cy_i,
  input  wire logic signed [Z_W-1:0]  z_i,
  input  wire side_t                  side_i,
  output logic                        vld_o,
  output logic signed [CX_W-1:0]      cx_o,
  output logic signed [CX_W-1:0]      cy_o,
  output logic signed [Z_W-1:0]       z_o,
  output side_t                       side_o
);

  logic signed [CX_W-1:0] shx, shy, cx_d, cy_d, cx_q, cy_q;
  logic signed [Z_W-1:0]  z_d, z_q;
  logic                   vld_q;
  side_t                  side_q;

  always_comb begin
    shx = cx_i >>> idx_i;
    shy = cy_i >>> idx_i;
    if (!cy_i[CX_W-1]) begin
      cx_d = cx_i + shy;
      cy_d = cy_i - shx;
      z_d  = z_i + atan_deg(idx_i);
    end else begin
      cx_d = cx_i - shy;
      cy_d = cy_i + shx;
      z_d  = z_i - atan_deg(idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q   <= cx_d;
      cy_q   <= cy_d;
      z_q    <= z_d;
      side_q <= side_i;
    end
  end

  assign vld_o  = vld_q;
  assign cx_o   = cx_q;
  assign cy_o   = cy_q;
  assign z_o    = z_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// ===== hdl/vad_finish.sv =====
// Back end: clamps the quadrant angle, maps it to the selected form, rounds
// to the output scale and applies the vertical special cases. Depends on vad_pkg.
`default_nettype none

module vad_finish
  import vad_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic [1:0]            mode_i,
  input  wire logic                  vld_i,
  input  wire logic signed [Z_W-1:0] z_i,
  input  wire side_t                 side_i,
  output logic                       vld_o,
  output logic signed [OUT_W-1:0]    angle_o
);

  logic is_line, is_full;

  always_comb begin
    unique case (mode_i)
      MODE_LINE: begin
        is_line = 1'b1;
        is_full = 1'b0;
      end
      MODE_SIGNED: begin
        is_line = 1'b0;
        is_full = 1'b0;
      end
      default: begin
        is_line = 1'b0;
        is_full = 1'b1;
      end
    endcase
  end

  // Stage 1: clamp and quadrant mapping in 2^-16 degree units.
  logic signed [Z_W-1:0]   zc;
  logic signed [ANG_W-1:0] a, t_d, t_q;
  logic                    vld1_q;
  side_t                   side1_q;

  always_comb begin
    if (z_i[Z_W-1])      zc = '0;
    else if (z_i > Z_DEG90) zc = Z_DEG90;
    else                 zc = z_i;
    a = side_i.dy_zero ? '0 : ANG_W'(zc);
    if (is_line) begin
      t_d = (side_i.dx_pos == !side_i.dy_neg) ? a : -a;
    end else begin
      t_d = side_i.dx_pos ? a : (T_DEG180 - a);
      if (side_i.dy_neg) t_d = -t_d;
      if (is_full && side_i.dy_neg) t_d = t_d + T_DEG360;
    end
  end

  // Stage 2: rounding (ties toward plus infinity), wrap and special cases.
  logic signed [ANG_W-1:0] r, res_d;
  logic signed [OUT_W-1:0] angle_q;
  logic                    vld2_q;

  always_comb begin
    r = (t_q + T_HALF) >>> RND_S;
    if (is_full && r == R_DEG360) r = '0;
    priority if (!side1_q.dx_zero) begin
      res_d = r;
    end else if (is_line || (!side1_q.dy_zero && !side1_q.dy_neg)) begin
      res_d = R_DEG90;
    end else if (side1_q.dy_neg) begin
      res_d = is_full ? R_DEG270 : R_DEGM90;
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= t_d;
      side1_q <= side_i;
      angle_q <= res_d[OUT_W-1:0];
    end
  end

  assign vld_o   = vld2_q;
  assign angle_o = angle_q;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking bench for vector_angle_degrees_core: streams point pairs
// through the core under all angle modes and compares each angle with a
// bit-exact CORDIC predictor. Depends on vad_pkg and the core RTL.
`default_nettype none

module tb
  import vad_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT    = CORDIC_STAGES + 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PER_PHASE = 52;
  localparam int NUM_PHASES  = 7;
  // The register keeps two bits; the unused code must act as full circle.
  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam longint NORM_LIMIT = 64'sd1 <<< 58;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ey;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] sx;
  } point_pair_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [1:0]             cfg_wdata_i = MODE_FULL;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // start_x, start_y, end_x, end_y
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;        // angle_out, zero pad

  // atan(2^-i) in degrees with 16 fraction bits.
  longint atan_deg_lut [0:17] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29
  };
  logic [1:0] mode_seq [0:NUM_PHASES-1] = '{
    MODE_FULL, MODE_SIGNED, MODE_LINE, MODE_UNDEF, MODE_LINE, MODE_SIGNED, MODE_FULL
  };

  point_pair_t        pending_pts[$];
  logic [OUT_W-1:0]   angle_exp_q[$];
  logic [OUT_W-1:0]   angle_exp;
  logic [1:0]         cur_mode = MODE_FULL;
  logic               in_taken = 1'b0;
  logic               burst_tx = 1'b0;
  logic               burst_rx = 1'b0;
  int                 tx_gap = 0;
  int                 rx_stall = 0;
  int                 n_queued = 0;
  int                 n_accepted = 0;
  int                 n_errors = 0;
  int                 cycle_cnt = 0;

  vector_angle_degrees_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Angle of (end - start) in units of 2^-FRAC_BITS degree.
  function automatic logic [OUT_W-1:0] predict_angle(input logic [1:0] mode,
                                                     input point_pair_t p);
    longint dx, dy, ax, ay, cx, cy, shx, shy, z, t, res;
    longint one_deg;
    logic [1:0] m;
    int i;
    one_deg = longint'(1) <<< FRAC_BITS;
    m = (mode == MODE_UNDEF) ? MODE_FULL : mode;
    dx = longint'(p.ex) - longint'(p.sx);
    dy = longint'(p.ey) - longint'(p.sy);
    if (dx == 0) begin
      if (m == MODE_LINE || dy > 0) begin
        res = 90 * one_deg;
      end else if (dy < 0) begin
        res = (m == MODE_FULL) ? 270 * one_deg : -90 * one_deg;
      end else begin
        res = 0;
      end
    end else begin
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      z = 0;
      if (ay != 0) begin
        while (ax < NORM_LIMIT && ay < NORM_LIMIT) begin
          ax = ax <<< 1;
          ay = ay <<< 1;
        end
        cx = ax;
        cy = ay;
        for (i = 0; i < CORDIC_STAGES; i++) begin
          shx = cx >>> i;
          shy = cy >>> i;
          if (cy >= 0) begin
            cx = cx + shy;
            cy = cy - shx;
            z = z + atan_deg_lut[i];
          end else begin
            cx = cx - shy;
            cy = cy + shx;
            z = z - atan_deg_lut[i];
          end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) <<< ANG_FRAC)) z = longint'(90) <<< ANG_FRAC;
      end
      if (m == MODE_LINE) begin
        t = ((dx > 0) == (dy >= 0)) ? z : -z;
        res = (t + (longint'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
      end else begin
        t = (dx > 0) ? z : ((longint'(180) <<< ANG_FRAC) - z);
        if (dy < 0) t = -t;
        if (m == MODE_FULL && dy < 0) t = t + (longint'(360) <<< ANG_FRAC);
        res = (t + (longint'(1) <<< (ANG_FRAC - FRAC_BITS - 1))) >>> (ANG_FRAC - FRAC_BITS);
        // A full-circle angle that rounds up to 360 wraps to 0.
        if (m == MODE_FULL && res == 360 * one_deg) res = 0;
      end
    end
    return res[OUT_W-1:0];
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return COORD_BITS'($urandom);
    if (r < 17) return COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
    case ($urandom_range(0, 3))
      0:       return COORD_BITS'(-32768);
      1:       return COORD_BITS'(-32767);
      2:       return COORD_BITS'(32766);
      default: return COORD_BITS'(32767);
    endcase
  endfunction

  task automatic queue_pts(input int sx, input int sy, input int ex, input int ey);
    point_pair_t p;
    p.sx = COORD_BITS'(sx);
    p.sy = COORD_BITS'(sy);
    p.ex = COORD_BITS'(ex);
    p.ey = COORD_BITS'(ey);
    pending_pts.push_back(p);
    n_queued++;
  endtask

  task automatic queue_random_pts();
    point_pair_t p;
    p.sx = rand_coord();
    p.sy = rand_coord();
    p.ex = rand_coord();
    p.ey = rand_coord();
    case ($urandom_range(0, 19))
      0, 1: p.ex = p.sx;
      2, 3: p.ey = p.sy;
      4: begin
        p.ex = p.sx;
        p.ey = p.sy;
      end
      // Nearly horizontal vectors stress the rounding near 0, 180 and 360.
      5: p.ey = COORD_BITS'(p.sy + (($urandom_range(0, 1) != 0) ? 1 : -1));
      default: ;
    endcase
    pending_pts.push_back(p);
    n_queued++;
  endtask

  task automatic queue_directed();
    queue_pts(0, 0, 0, 0);
    queue_pts(0, 0, 0, 5);
    queue_pts(0, 0, 0, -5);
    queue_pts(5, 5, 5, -32768);
    queue_pts(100, 100, -7, 100);
    queue_pts(0, 0, 9, 0);
    queue_pts(-32768, -32768, 32767, 32767);
    queue_pts(32767, 32767, -32768, -32768);
    queue_pts(32767, -32768, -32768, 32767);
    queue_pts(-32768, 32767, 32767, -32768);
    queue_pts(0, 0, 1, 1);
    queue_pts(0, 0, -1, 1);
    queue_pts(0, 0, -1, -1);
    queue_pts(0, 0, 1, -1);
    queue_pts(-32768, 0, 32767, -1);
    queue_pts(-32768, 0, 32767, 1);
    queue_pts(32767, 0, -32768, -1);
    queue_pts(32767, 0, -32768, 1);
    queue_pts(0, 0, 1, 32767);
    queue_pts(0, 0, -1, -32768);
    queue_pts(0, 0, 3, 4);
  endtask

  // Waits until every queued item has been accepted and has produced its
  // angle, then lets the pipeline settle.
  task automatic drain_pipeline();
    do @(negedge clk_i); while (n_accepted != n_queued || angle_exp_q.size() != 0);
    repeat (PIPE_LAT + 4) @(negedge clk_i);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    drain_pipeline();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = mode;
  endtask

  // Sender: a new item goes out once the previous one was taken.
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pts.size() != 0) begin
        s_axis_tdata <= pending_pts.pop_front();
        s_axis_tvalid <= 1'b1;
        tx_gap <= burst_tx ? 0 : idle_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) begin
    if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall <= burst_rx ? 0 : idle_len();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d angles outstanding", $time, angle_exp_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        angle_exp_q.push_back(predict_angle(cur_mode, point_pair_t'(s_axis_tdata)));
        n_accepted = n_accepted + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (angle_exp_q.size() == 0) begin
          $display("%0t: unexpected angle, expected none, got %0d", $time,
                   $signed(m_axis_tdata[OUT_W-1:0]));
          n_errors = n_errors + 1;
        end else begin
          angle_exp = angle_exp_q.pop_front();
          if (m_axis_tdata[OUT_W-1:0] !== angle_exp) begin
            $display("%0t: angle_out mismatch, expected %0d, got %0d", $time,
                     $signed(angle_exp), $signed(m_axis_tdata[OUT_W-1:0]));
            n_errors = n_errors + 1;
          end
        end
      end
    end
  end

  initial begin
    int ph;
    int k;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_mode(mode_seq[ph]);
      @(posedge clk_i);
      burst_tx = (ph % 3 == 1);
      burst_rx = (ph % 3 == 2);
      if (ph < 4) queue_directed();
      for (k = 0; k < RAND_PER_PHASE; k++) queue_random_pts();
    end
    drain_pipeline();
    if (n_errors == 0 && angle_exp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/vad_pkg.sv
hdl/vad_prep.sv
hdl/vad_cordic_stage.sv
hdl/vad_finish.sv
hdl/vector_angle_degrees_core.sv
test/tb.sv
